// ----- hw/rtl/msdr_pkg.sv -----
// shared widths, register indexes and lane types for the masked sum reducer
package msdr_pkg;

    // field widths
    localparam int WORD_W  = 63;
    localparam int PLAIN_W = 32;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CIPHER_MODULUS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAIN_MODULUS  = 1'd1;

    // reset values of the moduli
    localparam logic [WORD_W-1:0]  CIPHER_MOD_RESET = 63'd2;
    localparam logic [PLAIN_W-1:0] PLAIN_MOD_RESET  = 32'd2;

    // number of cells in each remainder chain, one per operand bit
    localparam int Q_CELLS = WORD_W;
    localparam int T_CELLS = WORD_W;

    // lane passed between mod-q cells
    typedef struct packed {
        logic              vld;
        logic [WORD_W-1:0] cw;   // cipher word bits not yet consumed, msb first
        logic [WORD_W-1:0] mw;   // mask word bits not yet consumed, msb first
        logic [WORD_W-1:0] ra;   // running remainder of cipher word mod q
        logic [WORD_W-1:0] rb;   // running remainder of mask word mod q
    } t_qlane;

    // lane passed between mod-t cells
    typedef struct packed {
        logic               vld;
        logic               neg;  // centered value is negative
        logic [WORD_W-1:0]  m;    // magnitude bits not yet consumed, msb first
        logic [PLAIN_W-1:0] r;    // running remainder of magnitude mod t
    } t_tlane;

    // lane between the two centering stages
    typedef struct packed {
        logic              vld;
        logic [WORD_W-1:0] sum;  // modular sum below q
    } t_slane;

endpackage

// ----- hw/rtl/msdr_modq_cell.sv -----
// one restoring remainder step modulo q for both operands
module msdr_modq_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic [msdr_pkg::WORD_W-1:0]       i_modulus,
    input  msdr_pkg::t_qlane                  i_lane,
    output msdr_pkg::t_qlane                  o_lane
);

    msdr_pkg::t_qlane                r_lane;
    msdr_pkg::t_qlane                n_lane;
    logic [msdr_pkg::WORD_W:0]       w_sh_a;
    logic [msdr_pkg::WORD_W:0]       w_sh_b;
    logic [msdr_pkg::WORD_W+1:0]     w_dif_a;
    logic [msdr_pkg::WORD_W+1:0]     w_dif_b;

    // shift in the next operand bit and subtract q when it fits
    always_comb begin
        w_sh_a  = {i_lane.ra, i_lane.cw[msdr_pkg::WORD_W-1]};
        w_sh_b  = {i_lane.rb, i_lane.mw[msdr_pkg::WORD_W-1]};
        w_dif_a = {1'b0, w_sh_a} - {2'b00, i_modulus};
        w_dif_b = {1'b0, w_sh_b} - {2'b00, i_modulus};
        n_lane.vld = i_lane.vld;
        n_lane.cw  = {i_lane.cw[msdr_pkg::WORD_W-2:0], 1'b0};
        n_lane.mw  = {i_lane.mw[msdr_pkg::WORD_W-2:0], 1'b0};
        n_lane.ra  = w_dif_a[msdr_pkg::WORD_W+1] ? w_sh_a[msdr_pkg::WORD_W-1:0]
                                                 : w_dif_a[msdr_pkg::WORD_W-1:0];
        n_lane.rb  = w_dif_b[msdr_pkg::WORD_W+1] ? w_sh_b[msdr_pkg::WORD_W-1:0]
                                                 : w_dif_b[msdr_pkg::WORD_W-1:0];
    end

    // lane register: valid bit is reset, payload is not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.vld <= 1'b0;
        end else if (i_en) begin
            r_lane.vld <= n_lane.vld;
        end
        if (i_en) begin
            r_lane.cw <= n_lane.cw;
            r_lane.mw <= n_lane.mw;
            r_lane.ra <= n_lane.ra;
            r_lane.rb <= n_lane.rb;
        end
    end

    assign o_lane = r_lane;

endmodule

// ----- hw/rtl/msdr_center.sv -----
// modular sum of the two remainders and centering around zero
module msdr_center (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic [msdr_pkg::WORD_W-1:0]       i_modulus,
    input  msdr_pkg::t_qlane                  i_lane,
    output msdr_pkg::t_tlane                  o_lane
);

    msdr_pkg::t_slane                r_sum;
    msdr_pkg::t_slane                n_sum;
    msdr_pkg::t_tlane                r_lane;
    msdr_pkg::t_tlane                n_lane;
    logic [msdr_pkg::WORD_W:0]       w_add;
    logic [msdr_pkg::WORD_W+1:0]     w_dif;
    logic [msdr_pkg::WORD_W-1:0]     w_half;

    // stage one: a + b, take off q once when reached
    always_comb begin
        w_add = {1'b0, i_lane.ra} + {1'b0, i_lane.rb};
        w_dif = {1'b0, w_add} - {2'b00, i_modulus};
        n_sum.vld = i_lane.vld;
        n_sum.sum = w_dif[msdr_pkg::WORD_W+1] ? w_add[msdr_pkg::WORD_W-1:0]
                                              : w_dif[msdr_pkg::WORD_W-1:0];
    end

    // stage two: values above q/2 become negative with magnitude q - s
    always_comb begin
        w_half     = {1'b0, i_modulus[msdr_pkg::WORD_W-1:1]};
        n_lane.vld = r_sum.vld;
        n_lane.neg = r_sum.sum > w_half;
        n_lane.m   = n_lane.neg ? (i_modulus - r_sum.sum) : r_sum.sum;
        n_lane.r   = '0;
    end

    // stage registers: valid bits are reset, payload is not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum.vld  <= 1'b0;
            r_lane.vld <= 1'b0;
        end else if (i_en) begin
            r_sum.vld  <= n_sum.vld;
            r_lane.vld <= n_lane.vld;
        end
        if (i_en) begin
            r_sum.sum  <= n_sum.sum;
            r_lane.neg <= n_lane.neg;
            r_lane.m   <= n_lane.m;
            r_lane.r   <= n_lane.r;
        end
    end

    assign o_lane = r_lane;

endmodule

// ----- hw/rtl/msdr_modt_cell.sv -----
// one restoring remainder step of the centered magnitude modulo t
module msdr_modt_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic [msdr_pkg::PLAIN_W-1:0]      i_modulus,
    input  msdr_pkg::t_tlane                  i_lane,
    output msdr_pkg::t_tlane                  o_lane
);

    msdr_pkg::t_tlane                r_lane;
    msdr_pkg::t_tlane                n_lane;
    logic [msdr_pkg::PLAIN_W:0]      w_sh;
    logic [msdr_pkg::PLAIN_W+1:0]    w_dif;

    // shift in the next magnitude bit and subtract t when it fits
    always_comb begin
        w_sh  = {i_lane.r, i_lane.m[msdr_pkg::WORD_W-1]};
        w_dif = {1'b0, w_sh} - {2'b00, i_modulus};
        n_lane.vld = i_lane.vld;
        n_lane.neg = i_lane.neg;
        n_lane.m   = {i_lane.m[msdr_pkg::WORD_W-2:0], 1'b0};
        n_lane.r   = w_dif[msdr_pkg::PLAIN_W+1] ? w_sh[msdr_pkg::PLAIN_W-1:0]
                                                : w_dif[msdr_pkg::PLAIN_W-1:0];
    end

    // lane register: valid bit is reset, payload is not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.vld <= 1'b0;
        end else if (i_en) begin
            r_lane.vld <= n_lane.vld;
        end
        if (i_en) begin
            r_lane.neg <= n_lane.neg;
            r_lane.m   <= n_lane.m;
            r_lane.r   <= n_lane.r;
        end
    end

    assign o_lane = r_lane;

endmodule

// ----- hw/rtl/masked_sum_decrypt_reduce_core.sv -----
// top level: masked sum decryption with centered mod-q to mod-t reduction
//
// Usage: each request on the input channel carries a cipher word and its mask
// word; one request on the output channel returns the plain value for it.
// Both channels use valid/stall; a request moves when valid is high and
// stall is low. q and t are written through the plain write port
// (index 0 = cipher modulus, index 1 = plain modulus); the user must write them
// only while the block is idle, which the block itself does not enforce. From
// input acceptance to o_valid a request passes 63 mod-q cells, two centering
// stages, 63 mod-t cells and the output register, one bit of the remainder
// chains per cell. Throughput is one request per cycle while o_stall is low.
// The output side has an output register plus one skid entry; the whole chain
// halts only while the skid entry is occupied, and o_stall is that skid flag
// straight from a register; the input halts only once two results wait.
// Reset clears all valid bits and the skid, and sets q and t to 2.
// A q or t below two yields a plain value of zero.
module masked_sum_decrypt_reduce_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [msdr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [msdr_pkg::WORD_W-1:0]           i_cfg_data,
    // input channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [msdr_pkg::WORD_W-1:0]           i_cipher_word,
    input  logic [msdr_pkg::WORD_W-1:0]           i_mask_word,
    // output channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [msdr_pkg::PLAIN_W-1:0]          o_plain_value
);

    logic [msdr_pkg::WORD_W-1:0]   r_cipher_mod;
    logic [msdr_pkg::PLAIN_W-1:0]  r_plain_mod;
    logic                          w_en;
    msdr_pkg::t_qlane              w_qlane [0:msdr_pkg::Q_CELLS];
    msdr_pkg::t_tlane              w_tlane [0:msdr_pkg::T_CELLS];
    logic                          w_zero;
    logic [msdr_pkg::PLAIN_W-1:0]  w_result;
    logic                          w_push;
    logic                          w_pop;
    logic                          r_out_valid;
    logic [msdr_pkg::PLAIN_W-1:0]  r_out_value;
    logic                          r_skid_valid;
    logic [msdr_pkg::PLAIN_W-1:0]  r_skid_value;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cipher_mod <= msdr_pkg::CIPHER_MOD_RESET;
            r_plain_mod  <= msdr_pkg::PLAIN_MOD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                msdr_pkg::CFG_CIPHER_MODULUS: r_cipher_mod <= i_cfg_data;
                msdr_pkg::CFG_PLAIN_MODULUS:  r_plain_mod  <= i_cfg_data[msdr_pkg::PLAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // the chain advances unless the skid entry holds a result
    assign w_en    = !r_skid_valid;
    assign o_stall = r_skid_valid;

    // head of the mod-q chain
    assign w_qlane[0].vld = i_valid;
    assign w_qlane[0].cw  = i_cipher_word;
    assign w_qlane[0].mw  = i_mask_word;
    assign w_qlane[0].ra  = '0;
    assign w_qlane[0].rb  = '0;

    // mod-q cells
    for (genvar g = 0; g < msdr_pkg::Q_CELLS; g++) begin : g_qcell
        msdr_modq_cell u_qcell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_en),
            .i_modulus (r_cipher_mod),
            .i_lane    (w_qlane[g]),
            .o_lane    (w_qlane[g+1])
        );
    end

    // modular sum and centering
    msdr_center u_center (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_modulus (r_cipher_mod),
        .i_lane    (w_qlane[msdr_pkg::Q_CELLS]),
        .o_lane    (w_tlane[0])
    );

    // mod-t cells
    for (genvar g = 0; g < msdr_pkg::T_CELLS; g++) begin : g_tcell
        msdr_modt_cell u_tcell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_en),
            .i_modulus (r_plain_mod),
            .i_lane    (w_tlane[g]),
            .o_lane    (w_tlane[g+1])
        );
    end

    // sign fix-up: negative values map to t - r, zero stays zero
    always_comb begin
        w_zero = (r_cipher_mod < msdr_pkg::WORD_W'(2)) || (r_plain_mod < msdr_pkg::PLAIN_W'(2));
        if (w_zero) begin
            w_result = '0;
        end else if (w_tlane[msdr_pkg::T_CELLS].neg && (w_tlane[msdr_pkg::T_CELLS].r != '0)) begin
            w_result = r_plain_mod - w_tlane[msdr_pkg::T_CELLS].r;
        end else begin
            w_result = w_tlane[msdr_pkg::T_CELLS].r;
        end
    end

    assign w_push = w_en && w_tlane[msdr_pkg::T_CELLS].vld;
    assign w_pop  = r_out_valid && !i_stall;

    // output register and skid entry, control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_push;
            end
        end else if (w_push) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // output register and skid entry, data
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_skid_valid) begin
                r_out_value <= r_skid_value;
            end else if (w_push) begin
                r_out_value <= w_result;
            end
        end else if (w_push) begin
            if (r_out_valid) begin
                r_skid_value <= w_result;
            end else begin
                r_out_value <= w_result;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_plain_value = r_out_value;

    // skid entry is only ever used behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // a draining skid entry leaves the output register valid
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry did not drain into output register");

    // every delivered value lies below the plain modulus when that modulus is at least two
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_plain_mod >= msdr_pkg::PLAIN_W'(2))) |-> (r_out_value < r_plain_mod))
        else $error("plain value not below plain modulus");

endmodule
